/* src/clex_pkg.sv */
// ----------------------------------------------------------------------------
// clex_pkg
// Shared types, character classes and keyword tables of the subset lexer.
// ----------------------------------------------------------------------------
package clex_pkg;

  typedef enum logic [3:0] {
    TK_EOF     = 4'd0,
    TK_SEMI    = 4'd1,
    TK_LPAR    = 4'd2,
    TK_RPAR    = 4'd3,
    TK_LBRACE  = 4'd4,
    TK_RBRACE  = 4'd5,
    TK_CONST   = 4'd6,
    TK_INT     = 4'd7,
    TK_VOID    = 4'd8,
    TK_RETURN  = 4'd9,
    TK_IDENT   = 4'd10,
    TK_INVALID = 4'd11
  } tok_e;

  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // name buffer lengths never exceed 63, so positions travel in 6 bits
  localparam int unsigned PosW = 6;

  // one result word as it leaves the block, line number aside
  typedef struct packed {
    tok_e        kind;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        ovf;
    logic        last;
  } result_t;

  // name buffer write command, seen by the keyword tracker
  typedef struct packed {
    logic            first;
    logic            append;
    logic [PosW-1:0] pos;
    logic [7:0]      ch;
  } name_wr_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
           (b == 8'h5f);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0c};
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return b inside {8'h3b, 8'h28, 8'h29, 8'h7b, 8'h7d};
  endfunction

  function automatic tok_e punct_kind(input logic [7:0] b);
    tok_e k;
    case (b)
      8'h3b:   k = TK_SEMI;
      8'h28:   k = TK_LPAR;
      8'h29:   k = TK_RPAR;
      8'h7b:   k = TK_LBRACE;
      8'h7d:   k = TK_RBRACE;
      default: k = TK_INVALID;
    endcase
    return k;
  endfunction

  // keyword characters by position, zero past the end (never a letter)
  function automatic logic [7:0] kw_int_ch(input logic [PosW-1:0] p);
    logic [7:0] c;
    case (p)
      6'd0:    c = 8'h69; // i
      6'd1:    c = 8'h6e; // n
      6'd2:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_void_ch(input logic [PosW-1:0] p);
    logic [7:0] c;
    case (p)
      6'd0:    c = 8'h76; // v
      6'd1:    c = 8'h6f; // o
      6'd2:    c = 8'h69; // i
      6'd3:    c = 8'h64; // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_ret_ch(input logic [PosW-1:0] p);
    logic [7:0] c;
    case (p)
      6'd0:    c = 8'h72; // r
      6'd1:    c = 8'h65; // e
      6'd2:    c = 8'h74; // t
      6'd3:    c = 8'h75; // u
      6'd4:    c = 8'h72; // r
      6'd5:    c = 8'h6e; // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* src/clex_name_ram.sv */
// ----------------------------------------------------------------------------
// clex_name_ram
// Identifier character buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clex_name_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/clex_kw_track.sv */
// ----------------------------------------------------------------------------
// clex_kw_track
// Follows the writes into the name buffer and flags int, void and return.
// ----------------------------------------------------------------------------
module clex_kw_track
  import clex_pkg::*;
#(
  parameter int unsigned LenW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  name_wr_t        wr_i,
  input  logic [LenW-1:0] len_i,
  input  logic            ovf_i,
  output logic            hit_o,
  output tok_e            kind_o
);

  logic int_ok_q, int_ok_d;
  logic void_ok_q, void_ok_d;
  logic ret_ok_q, ret_ok_d;

  always_comb begin
    int_ok_d  = int_ok_q;
    void_ok_d = void_ok_q;
    ret_ok_d  = ret_ok_q;
    if (wr_i.first) begin
      int_ok_d  = (wr_i.ch == kw_int_ch('0));
      void_ok_d = (wr_i.ch == kw_void_ch('0));
      ret_ok_d  = (wr_i.ch == kw_ret_ch('0));
    end else if (wr_i.append) begin
      int_ok_d  = int_ok_q  & (wr_i.ch == kw_int_ch(wr_i.pos));
      void_ok_d = void_ok_q & (wr_i.ch == kw_void_ch(wr_i.pos));
      ret_ok_d  = ret_ok_q  & (wr_i.ch == kw_ret_ch(wr_i.pos));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_ok_q  <= 1'b0;
      void_ok_q <= 1'b0;
      ret_ok_q  <= 1'b0;
    end else begin
      int_ok_q  <= int_ok_d;
      void_ok_q <= void_ok_d;
      ret_ok_q  <= ret_ok_d;
    end
  end

  always_comb begin
    hit_o  = 1'b0;
    kind_o = TK_IDENT;
    if (!ovf_i) begin
      if (int_ok_q && (len_i == LenW'(3))) begin
        hit_o  = 1'b1;
        kind_o = TK_INT;
      end else if (void_ok_q && (len_i == LenW'(4))) begin
        hit_o  = 1'b1;
        kind_o = TK_VOID;
      end else if (ret_ok_q && (len_i == LenW'(6))) begin
        hit_o  = 1'b1;
        kind_o = TK_RETURN;
      end
    end
  end

endmodule

/* src/c_subset_lexer_unit.sv */
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Tokenizer for a small C subset, one source byte per input word.
// ----------------------------------------------------------------------------
// A byte is first accepted and then classified against the current scan mode.
// A byte that closes a constant or keyword is classified again once the closed
// token is out; a byte that closes any other identifier is classified again
// once every stored character has been sent. Identifier characters are kept
// in a buffer memory with one write port and a registered read port and are
// emitted one word per cycle while the output side takes them; input is held
// off during that flush. Keywords are recognized while the name is written, so
// they leave in one word. After an end-of-file or error token the block swallows
// all further input until reset. A result waits in an output register, so the
// next byte is taken while a token is still being drained.
module c_subset_lexer_unit
  import clex_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
  input  logic        s_axis_tuser,  // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [31:0] const_value, [39:32] text_char,
                                     // [40] text_overflow, [72:41] line_number
  output logic [3:0]  m_axis_tuser,  // [3:0] token_kind
  output logic        m_axis_tlast
);

  localparam int unsigned AddrW = $clog2(MAX_NAME_LEN);
  localparam int unsigned LenW  = $clog2(MAX_NAME_LEN + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FLUSH, ST_HALT} state_e;
  typedef enum logic [1:0] {MD_IDLE, MD_NUM, MD_NAME} mode_e;

  state_e           st_q, st_d;
  mode_e            mode_q, mode_d;
  logic [31:0]      acc_q, acc_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [31:0]      line_q, line_d;
  logic [7:0]       byte_q, byte_d;
  logic             eof_q, eof_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             out_vld_q, out_vld_d;
  result_t          out_q, out_d;
  logic [31:0]      out_line_q, out_line_d;

  logic             out_free;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  name_wr_t         nwr;
  logic             kw_hit;
  tok_e             kw_kind;

  clex_name_ram #(
    .Depth (MAX_NAME_LEN),
    .AddrW (AddrW)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  clex_kw_track #(
    .LenW (LenW)
  ) u_kw_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (nwr),
    .len_i  (len_q),
    .ovf_i  (ovf_q),
    .hit_o  (kw_hit),
    .kind_o (kw_kind)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) || (st_q == ST_HALT);

  always_comb begin
    st_d       = st_q;
    mode_d     = mode_q;
    acc_d      = acc_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    line_d     = line_q;
    byte_d     = byte_q;
    eof_d      = eof_q;
    idx_d      = idx_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    out_line_d = out_line_q;
    ram_we     = 1'b0;
    ram_waddr  = len_q[AddrW-1:0];
    ram_re     = 1'b0;
    ram_raddr  = idx_q;
    nwr        = '0;
    nwr.ch     = byte_q;
    nwr.pos    = PosW'(len_q);

    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          byte_d = s_axis_tdata;
          eof_d  = s_axis_tuser;
          if (!s_axis_tuser && (s_axis_tdata == CH_NL)) begin
            line_d = line_q + 32'd1;
          end
          st_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (mode_q)
          MD_NUM: begin
            if (!eof_q && is_digit(byte_q)) begin
              acc_d = (acc_q << 3) + (acc_q << 1) + 32'(byte_q - CH_ZERO);
              st_d  = ST_IDLE;
            end else if (out_free) begin
              out_vld_d  = 1'b1;
              out_d      = '{kind: TK_CONST, value: acc_q, ch: 8'h00, ovf: 1'b0,
                             last: 1'b1};
              out_line_d = line_q;
              acc_d      = '0;
              mode_d     = MD_IDLE;  // closing byte is classified next cycle
            end
          end

          MD_NAME: begin
            if (!eof_q && is_letter(byte_q)) begin
              if (len_q < LenW'(MAX_NAME_LEN)) begin
                ram_we     = 1'b1;
                nwr.append = 1'b1;
                len_d      = len_q + LenW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              st_d = ST_IDLE;
            end else if (kw_hit) begin
              if (out_free) begin
                out_vld_d  = 1'b1;
                out_d      = '{kind: kw_kind, value: 32'd0, ch: 8'h00, ovf: 1'b0,
                               last: 1'b1};
                out_line_d = line_q;
                len_d      = '0;
                ovf_d      = 1'b0;
                mode_d     = MD_IDLE;
              end
            end else begin
              // start the flush with the first stored character
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              st_d      = ST_FLUSH;
            end
          end

          default: begin
            if (eof_q) begin
              if (out_free) begin
                out_vld_d  = 1'b1;
                out_d      = '{kind: TK_EOF, value: 32'd0, ch: 8'h00, ovf: 1'b0,
                               last: 1'b1};
                out_line_d = line_q;
                st_d       = ST_HALT;
              end
            end else if (is_space(byte_q)) begin
              st_d = ST_IDLE;
            end else if (is_punct(byte_q)) begin
              if (out_free) begin
                out_vld_d  = 1'b1;
                out_d      = '{kind: punct_kind(byte_q), value: 32'd0, ch: 8'h00,
                               ovf: 1'b0, last: 1'b1};
                out_line_d = line_q;
                st_d       = ST_IDLE;
              end
            end else if (is_digit(byte_q)) begin
              acc_d  = 32'(byte_q - CH_ZERO);
              mode_d = MD_NUM;
              st_d   = ST_IDLE;
            end else if (is_letter(byte_q)) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              nwr.first = 1'b1;
              len_d     = LenW'(1);
              ovf_d     = 1'b0;
              mode_d    = MD_NAME;
              st_d      = ST_IDLE;
            end else if (out_free) begin
              out_vld_d  = 1'b1;
              out_d      = '{kind: TK_INVALID, value: 32'd0, ch: byte_q, ovf: 1'b0,
                             last: 1'b1};
              out_line_d = line_q;
              st_d       = ST_HALT;
            end
          end
        endcase
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_line_d = line_q;
          if ((LenW'(idx_q) + LenW'(1)) == len_q) begin
            out_d  = '{kind: TK_IDENT, value: 32'd0, ch: ram_rdata, ovf: ovf_q,
                       last: 1'b1};
            len_d  = '0;
            ovf_d  = 1'b0;
            mode_d = MD_IDLE;
            st_d   = ST_EXEC;
          end else begin
            out_d     = '{kind: TK_IDENT, value: 32'd0, ch: ram_rdata, ovf: ovf_q,
                          last: 1'b0};
            idx_d     = idx_q + AddrW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + AddrW'(1);
          end
        end
      end

      default: begin
        // halted: input words are taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      mode_q     <= MD_IDLE;
      acc_q      <= '0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      line_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      mode_q     <= mode_d;
      acc_q      <= acc_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      line_q     <= line_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    eof_q      <= eof_d;
    idx_q      <= idx_d;
    out_q      <= out_d;
    out_line_q <= out_line_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_line_q, out_q.ovf, out_q.ch, out_q.value};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subset lexer. Source text goes in one byte per
// word. A built-in tokenizer model predicts the token words, and each output
// word is checked against the oldest prediction. The stream ends with an
// end-of-file or error byte, and later words must be swallowed.
// ----------------------------------------------------------------------------
module tb
  import clex_pkg::*;
();

  localparam int unsigned NameMax = 32;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUM,
    SCAN_NAME,
    SCAN_HALT
  } scan_e;

  typedef struct {
    tok_e        kind;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        ovf;
    logic [31:0] line;
    logic        last;
  } lex_tok_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;  // [7:0] byte_in
  logic        s_axis_tuser;  // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;  // [31:0] const_value, [39:32] text_char,
                              // [40] text_overflow, [72:41] line_number
  logic [3:0]  m_axis_tuser;  // [3:0] token_kind
  logic        m_axis_tlast;

  // tokenizer model state
  scan_e       scan_mode;
  logic [31:0] num_acc;
  logic [7:0]  name_buf [NameMax];
  int unsigned name_len;
  logic        name_ovf;
  logic [31:0] line_cnt;

  lex_tok_t    tok_expect_q [$];
  lex_tok_t    want;
  int unsigned mismatch_cnt;
  int unsigned words_sent;
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned ready_hold = 0;

  c_subset_lexer_unit #(
    .MAX_NAME_LEN(NameMax)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic src_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic src_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic void push_expect(input tok_e k, input logic [31:0] v,
                                      input logic [7:0] c, input logic o,
                                      input logic l);
    lex_tok_t t;
    t.kind  = k;
    t.value = v;
    t.ch    = c;
    t.ovf   = o;
    t.line  = line_cnt;
    t.last  = l;
    tok_expect_q.insert(tok_expect_q.size(), t);
  endfunction

  function automatic logic name_equals(input string kw);
    if (name_ovf || name_len != kw.len()) return 1'b0;
    for (int i = 0; i < kw.len(); i++) begin
      if (name_buf[i] != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void flush_name();
    if (name_equals("int")) begin
      push_expect(TK_INT, '0, '0, 1'b0, 1'b1);
    end else if (name_equals("void")) begin
      push_expect(TK_VOID, '0, '0, 1'b0, 1'b1);
    end else if (name_equals("return")) begin
      push_expect(TK_RETURN, '0, '0, 1'b0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < name_len; i++) begin
        push_expect(TK_IDENT, '0, name_buf[i], name_ovf, i + 1 == name_len);
      end
    end
    name_len = 0;
    name_ovf = 1'b0;
  endfunction

  function automatic void lex_predict(input logic [7:0] b, input logic eof);
    if (scan_mode == SCAN_HALT) return;
    if (!eof && b == CH_NL) line_cnt++;
    if (scan_mode == SCAN_NUM) begin
      if (!eof && src_digit(b)) begin
        num_acc = num_acc * 32'd10 + 32'(b - CH_ZERO);
        return;
      end
      push_expect(TK_CONST, num_acc, '0, 1'b0, 1'b1);
      num_acc   = '0;
      scan_mode = SCAN_IDLE;
    end else if (scan_mode == SCAN_NAME) begin
      if (!eof && src_letter(b)) begin
        if (name_len < NameMax) begin
          name_buf[name_len] = b;
          name_len++;
        end else begin
          name_ovf = 1'b1;
        end
        return;
      end
      flush_name();
      scan_mode = SCAN_IDLE;
    end
    // fresh byte, also the one that just closed a token
    if (eof) begin
      push_expect(TK_EOF, '0, '0, 1'b0, 1'b1);
      scan_mode = SCAN_HALT;
    end else if (b inside {" ", 8'h09, 8'h0a, 8'h0d, 8'h0c}) begin
      return;
    end else if (b == ";") begin
      push_expect(TK_SEMI, '0, '0, 1'b0, 1'b1);
    end else if (b == "(") begin
      push_expect(TK_LPAR, '0, '0, 1'b0, 1'b1);
    end else if (b == ")") begin
      push_expect(TK_RPAR, '0, '0, 1'b0, 1'b1);
    end else if (b == "{") begin
      push_expect(TK_LBRACE, '0, '0, 1'b0, 1'b1);
    end else if (b == "}") begin
      push_expect(TK_RBRACE, '0, '0, 1'b0, 1'b1);
    end else if (src_digit(b)) begin
      num_acc   = 32'(b - CH_ZERO);
      scan_mode = SCAN_NUM;
    end else if (src_letter(b)) begin
      name_buf[0] = b;
      name_len    = 1;
      name_ovf    = 1'b0;
      scan_mode   = SCAN_NAME;
    end else begin
      push_expect(TK_INVALID, '0, b, 1'b0, 1'b1);
      scan_mode = SCAN_HALT;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tok_expect_q.size() == 0) begin
        note_mismatch($sformatf(
          "unexpected word: kind=%0d value=%0d ch=%h ovf=%b line=%0d last=%b",
          m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
          m_axis_tdata[40], m_axis_tdata[72:41], m_axis_tlast));
      end else begin
        want = tok_expect_q.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.value ||
            m_axis_tdata[39:32] !== want.ch || m_axis_tdata[40] !== want.ovf ||
            m_axis_tdata[72:41] !== want.line || m_axis_tlast !== want.last) begin
          note_mismatch({
            $sformatf("token word differs: exp kind=%0d value=%0d ch=%h ovf=%b",
                      want.kind, want.value, want.ch, want.ovf),
            $sformatf(" line=%0d last=%b, got kind=%0d value=%0d ch=%h",
                      want.line, want.last, m_axis_tuser, m_axis_tdata[31:0],
                      m_axis_tdata[39:32]),
            $sformatf(" ovf=%b line=%0d last=%b",
                      m_axis_tdata[40], m_axis_tdata[72:41], m_axis_tlast)});
        end
      end
    end
  end

  // output side: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= ready_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input logic [7:0] b, input logic eof);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    lex_predict(b, eof);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tok_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    return "_";
  endfunction

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return " ";
    if (r < 7) return CH_NL;
    if (r == 7) return 8'h09;
    if (r == 8) return 8'h0d;
    return 8'h0c;
  endfunction

  task automatic send_name(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_word(rand_letter(), 1'b0);
  endtask

  task automatic send_lexeme();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(2))
        0:       send_text("int");
        1:       send_text("void");
        default: send_text("return");
      endcase
    end else if (r < 38) begin
      len = ($urandom_range(24) == 0) ? $urandom_range(NameMax - 2, NameMax + 8)
                                      : $urandom_range(1, 7);
      send_name(len);
    end else if (r < 58) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        push_word(8'("0" + $urandom_range(9)), 1'b0);
      end
    end else if (r < 80) begin
      case ($urandom_range(4))
        0:       push_word(";", 1'b0);
        1:       push_word("(", 1'b0);
        2:       push_word(")", 1'b0);
        3:       push_word("{", 1'b0);
        default: push_word("}", 1'b0);
      endcase
    end else begin
      len = $urandom_range(1, 3);
      for (int unsigned i = 0; i < len; i++) push_word(rand_space(), 1'b0);
    end
    // tokens often run into each other with no gap
    if ($urandom_range(99) < 55) push_word(rand_space(), 1'b0);
  endtask

  task automatic test_directed_tokens();
    send_text("int void return ret_Val;(){}");
    push_word(8'h09, 1'b0);
    push_word(8'h0d, 1'b0);
    push_word(8'h0c, 1'b0);
    send_text("4294967295 4294967296\nq9Z_\n7\n");
    send_text("intx in returnr _;");
    wait_drained();
  endtask

  task automatic test_long_names();
    send_name(NameMax);
    push_word(" ", 1'b0);
    send_name(NameMax + 1);
    push_word(";", 1'b0);
    send_name(NameMax + 28);
    push_word("5", 1'b0);
    push_word(CH_NL, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_source(input int unsigned n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) send_lexeme();
  endtask

  task automatic test_backpressure();
    int unsigned stop_at;
    ready_hold <= 300;
    stop_at = words_sent + 40;
    send_name(NameMax + 4);
    while (words_sent < stop_at) send_lexeme();
    // sender waits for all expected tokens to drain before going on
    wait_drained();
  endtask

  task automatic test_terminate_and_halt();
    send_name($urandom_range(1, 5));
    case ($urandom_range(3))
      0:       push_word(8'($urandom_range(255)), 1'b1);
      1:       push_word(8'h00, 1'b0);
      2:       push_word(8'hff, 1'b0);
      default: push_word(8'($urandom_range(128, 255)), 1'b0);
    endcase
    // halted: everything below must be swallowed
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(8'h41, 1'b1);
    for (int i = 0; i < 20; i++) begin
      push_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    send_text("int x;");
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    src_idle_pct  = 29;
    dst_idle_pct  = 66;
    mismatch_cnt  = 0;
    words_sent    = 0;
    scan_mode     = SCAN_IDLE;
    num_acc       = '0;
    name_len      = 0;
    name_ovf      = 1'b0;
    line_cnt      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_tokens();
    test_long_names();
    test_random_source(50);
    src_idle_pct <= 66;
    dst_idle_pct <= 29;
    test_random_source(50);
    test_backpressure();
    src_idle_pct <= 0;
    dst_idle_pct <= 0;
    test_random_source(50);
    test_terminate_and_halt();

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && tok_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
src/clex_pkg.sv
src/clex_name_ram.sv
src/clex_kw_track.sv
src/c_subset_lexer_unit.sv
verif/tb.sv
